### sv/mbc_pkg.sv
// mbc_pkg: shared types and constants for the masked bit crusher.
// Used by every module of the block; no dependencies.
`default_nettype none

package mbc_pkg;

  localparam int MASK_W    = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CRUSH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_XOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CUBE  = 3'd4;

  typedef struct packed {
    logic vld;
    logic neg;
  } ctl_t;

  typedef struct packed {
    logic              crush_enable;
    logic [MASK_W-1:0] bit_mask;
    logic              xor_enable;
    logic              and_enable;
    logic              cube_root_enable;
  } cfg_t;

endpackage

`default_nettype wire

### sv/mbc_front.sv
// mbc_front: input register; sign, saturated magnitude and cube-root target.
// Depends on mbc_pkg.
`default_nettype none

module mbc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  input  wire logic [SAMPLE_BITS-1:0]      up_sample,
  output      logic                        up_rdy,
  output      mbc_pkg::ctl_t               dn_ctl,
  output      logic [SAMPLE_BITS-1:0]      dn_raw,
  output      logic [SAMPLE_BITS-2:0]      dn_m,
  output      logic [3*(SAMPLE_BITS-1)-1:0] dn_tgt,
  input  wire logic                        dn_rdy
);

  localparam int W  = SAMPLE_BITS;
  localparam int N  = W - 1;
  localparam int TW = 3 * N;
  localparam logic [N-1:0] FS = {N{1'b1}};

  logic          v_r;
  logic          neg_r;
  logic [W-1:0]  raw_r;
  logic [N-1:0]  m_r;
  logic [TW-1:0] tgt_r;

  logic          neg_nxt;
  logic [W-1:0]  mag;
  logic [N-1:0]  m_nxt;
  logic [N:0]    mp1;
  logic [TW:0]   tgt_w;
  logic          load;

  always_comb begin
    neg_nxt = up_sample[W-1];
    mag     = neg_nxt ? (W'(0) - up_sample) : up_sample;
    m_nxt   = (mag > {1'b0, FS}) ? FS : mag[N-1:0];
    mp1     = {1'b0, m_nxt} + (N+1)'(1);
    // (m+1) * FS^2 with FS = 2^N - 1
    tgt_w   = ((TW+1)'(mp1) << (2*N)) - ((TW+1)'(mp1) << (N+1)) + (TW+1)'(mp1);
  end

  assign up_rdy = !v_r || dn_rdy;
  assign load   = up_valid && up_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= neg_nxt;
      raw_r <= up_sample;
      m_r   <= m_nxt;
      tgt_r <= tgt_w[TW-1:0];
    end
  end

  always_comb begin
    dn_ctl.vld = v_r;
    dn_ctl.neg = neg_r;
  end
  assign dn_raw = raw_r;
  assign dn_m   = m_r;
  assign dn_tgt = tgt_r;

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> v_r)
    else $error("front: accepted word not held");

endmodule

`default_nettype wire

### sv/mbc_root_cell.sv
// mbc_root_cell: one bit of the cube-root search, trial cube built by shifts and adds.
// Depends on mbc_pkg; chained by masked_bit_crusher.
`default_nettype none

module mbc_root_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int BIT         = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mbc_pkg::ctl_t                up_ctl,
  input  wire logic [SAMPLE_BITS-1:0]       up_raw,
  input  wire logic [SAMPLE_BITS-2:0]       up_m,
  input  wire logic [3*(SAMPLE_BITS-1)-1:0] up_tgt,
  input  wire logic [SAMPLE_BITS-2:0]       up_q,
  input  wire logic [2*(SAMPLE_BITS-1)-1:0] up_q2,
  input  wire logic [3*(SAMPLE_BITS-1)-1:0] up_q3,
  output      logic                         up_rdy,
  output      mbc_pkg::ctl_t                dn_ctl,
  output      logic [SAMPLE_BITS-1:0]       dn_raw,
  output      logic [SAMPLE_BITS-2:0]       dn_m,
  output      logic [3*(SAMPLE_BITS-1)-1:0] dn_tgt,
  output      logic [SAMPLE_BITS-2:0]       dn_q,
  output      logic [2*(SAMPLE_BITS-1)-1:0] dn_q2,
  output      logic [3*(SAMPLE_BITS-1)-1:0] dn_q3,
  input  wire logic                         dn_rdy
);

  localparam int W   = SAMPLE_BITS;
  localparam int N   = W - 1;
  localparam int SW  = 2 * N;
  localparam int TW  = 3 * N;

  logic          v_r;
  logic          neg_r;
  logic [W-1:0]  raw_r;
  logic [N-1:0]  m_r;
  logic [TW-1:0] tgt_r;
  logic [N-1:0]  q_r;
  logic [SW-1:0] q2_r;
  logic [TW-1:0] q3_r;

  logic [N-1:0]  q_nxt;
  logic [SW-1:0] q2_nxt;
  logic [TW-1:0] q3_nxt;
  logic [TW-1:0] t3;
  logic [SW-1:0] t2;
  logic [TW-1:0] a2;
  logic [TW-1:0] a1;
  logic          take;
  logic          load;

  // (q+d)^3 = q^3 + 3 q^2 d + 3 q d^2 + d^3, d = 2^BIT; q has no bits at or below BIT
  always_comb begin
    a2   = TW'(up_q2) << BIT;
    a1   = TW'(up_q) << (2*BIT);
    t3   = up_q3 + (a2 << 1) + a2 + (a1 << 1) + a1 + (TW'(1) << (3*BIT));
    t2   = up_q2 + (SW'(up_q) << (BIT+1)) + (SW'(1) << (2*BIT));
    take = t3 < up_tgt;
    q_nxt  = take ? (up_q | (N'(1) << BIT)) : up_q;
    q2_nxt = take ? t2 : up_q2;
    q3_nxt = take ? t3 : up_q3;
  end

  assign up_rdy = !v_r || dn_rdy;
  assign load   = up_ctl.vld && up_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= up_ctl.neg;
      raw_r <= up_raw;
      m_r   <= up_m;
      tgt_r <= up_tgt;
      q_r   <= q_nxt;
      q2_r  <= q2_nxt;
      q3_r  <= q3_nxt;
    end
  end

  always_comb begin
    dn_ctl.vld = v_r;
    dn_ctl.neg = neg_r;
  end
  assign dn_raw = raw_r;
  assign dn_m   = m_r;
  assign dn_tgt = tgt_r;
  assign dn_q   = q_r;
  assign dn_q2  = q2_r;
  assign dn_q3  = q3_r;

  a_cube_below_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (q3_r < tgt_r))
    else $error("root cell: partial cube reached target");

endmodule

`default_nettype wire

### sv/mbc_back.sv
// mbc_back: masking, cube, scale by 1/FS^2, sign restore and output register.
// Depends on mbc_pkg; fed by the last mbc_root_cell.
`default_nettype none

module mbc_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mbc_pkg::cfg_t          cfg,
  input  wire mbc_pkg::ctl_t          up_ctl,
  input  wire logic [SAMPLE_BITS-1:0] up_raw,
  input  wire logic [SAMPLE_BITS-2:0] up_m,
  input  wire logic [SAMPLE_BITS-2:0] up_q,
  output      logic                   up_rdy,
  output      logic                   out_valid,
  output      logic [SAMPLE_BITS-1:0] out_sample,
  input  wire logic                   out_stall
);

  localparam int W  = SAMPLE_BITS;
  localparam int N  = W - 1;
  localparam int SW = 2 * N;
  localparam int TW = 3 * N;
  localparam int RW = 2 * N + 2;
  localparam int MW = (N > mbc_pkg::MASK_W) ? N : mbc_pkg::MASK_W;
  localparam logic [RW-1:0] FS2   = (RW'(1) << (2*N)) - (RW'(1) << (N+1)) + RW'(1);
  localparam logic [RW-1:0] FS2X2 = FS2 << 1;
  localparam logic [RW-1:0] FS2X3 = FS2X2 + FS2;

  // stage 1: masked magnitude and its square
  logic          v1_r, neg1_r;
  logic [W-1:0]  raw1_r;
  logic [N-1:0]  qm1_r;
  logic [SW-1:0] sq1_r;
  // stage 2: cube
  logic          v2_r, neg2_r;
  logic [W-1:0]  raw2_r;
  logic [N-1:0]  qm2_r;
  logic [TW-1:0] cb2_r;
  // stage 3: quotient estimate and remainder
  logic          v3_r, neg3_r;
  logic [W-1:0]  raw3_r;
  logic [N-1:0]  qm3_r;
  logic [N-1:0]  r03_r;
  logic [RW-1:0] rem3_r;
  // output register
  logic          ov_r;
  logic [W-1:0]  out_r;

  logic          rdy1, rdy2, rdy3, rdy4;
  logic [MW-1:0] mask_w;
  logic [N-1:0]  mask_n;
  logic [N-1:0]  qm1_nxt;
  logic [SW-1:0] sq1_nxt;
  logic [TW-1:0] cb2_nxt;
  logic [N-1:0]  r03_nxt;
  logic [TW-1:0] prod;
  logic [TW-1:0] rem_full;
  logic [N-1:0]  r_cube;
  logic [N-1:0]  mag_o;
  logic [W-1:0]  signed_o;
  logic [W-1:0]  out_nxt;

  assign rdy4   = !ov_r || !out_stall;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  always_comb begin
    mask_w  = MW'(cfg.bit_mask);
    mask_n  = mask_w[N-1:0];
    qm1_nxt = cfg.cube_root_enable ? up_q : up_m;
    if (cfg.xor_enable) begin
      qm1_nxt = qm1_nxt ^ mask_n;
    end
    if (cfg.and_enable) begin
      qm1_nxt = qm1_nxt & mask_n;
    end
    sq1_nxt = SW'(qm1_nxt) * SW'(qm1_nxt);
  end

  assign cb2_nxt = TW'(sq1_r) * TW'(qm1_r);

  // floor(x / 2^2N) undershoots floor(x / FS^2) by at most two
  always_comb begin
    r03_nxt  = cb2_r[TW-1:2*N];
    prod     = (TW'(r03_nxt) << (2*N)) - (TW'(r03_nxt) << (N+1)) + TW'(r03_nxt);
    rem_full = cb2_r - prod;
  end

  always_comb begin
    r_cube   = r03_r + N'(rem3_r >= FS2) + N'(rem3_r >= FS2X2);
    mag_o    = cfg.cube_root_enable ? r_cube : qm3_r;
    signed_o = neg3_r ? (W'(0) - {1'b0, mag_o}) : {1'b0, mag_o};
    out_nxt  = cfg.crush_enable ? signed_o : raw3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_ctl.vld;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        ov_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ctl.vld && rdy1) begin
      neg1_r <= up_ctl.neg;
      raw1_r <= up_raw;
      qm1_r  <= qm1_nxt;
      sq1_r  <= sq1_nxt;
    end
    if (v1_r && rdy2) begin
      neg2_r <= neg1_r;
      raw2_r <= raw1_r;
      qm2_r  <= qm1_r;
      cb2_r  <= cb2_nxt;
    end
    if (v2_r && rdy3) begin
      neg3_r <= neg2_r;
      raw3_r <= raw2_r;
      qm3_r  <= qm2_r;
      r03_r  <= r03_nxt;
      rem3_r <= rem_full[RW-1:0];
    end
    if (v3_r && rdy4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_sample = out_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (rem3_r < FS2X3))
    else $error("back: remainder out of correction range");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(cb2_r)))
    else $error("back: stalled cube stage lost its word");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> v1_r)
    else $error("back: stalled square stage lost its word");

endmodule

`default_nettype wire

### sv/masked_bit_crusher.sv
// masked_bit_crusher: top level; configuration registers, front stage,
// chain of mbc_root_cell and mbc_back. Depends on mbc_pkg and those modules.
//
// Takes one signed sample word per clock and returns one crushed word per
// clock; a stall on the output holds the pipeline and, once it is full,
// stalls the input. Each word passes through one front register, one
// cube-root cell per magnitude bit, then the square, cube, scaling and
// output registers. Configuration is accepted every cycle and must be
// changed only while no word is in flight.
`default_nettype none

module masked_bit_crusher #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output      logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample_in,
  output      logic                                   out_valid,
  input  wire logic                                   out_stall,
  output      logic signed [SAMPLE_BITS-1:0]          out_sample_out,
  input  wire logic                                   cfg_valid,
  output      logic                                   cfg_ready,
  input  wire logic [mbc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mbc_pkg::CFG_DAT_W-1:0]          cfg_data
);

  localparam int W  = SAMPLE_BITS;
  localparam int N  = W - 1;
  localparam int SW = 2 * N;
  localparam int TW = 3 * N;

  mbc_pkg::cfg_t cfg_r;

  mbc_pkg::ctl_t c_ctl [0:N];
  logic [W-1:0]  c_raw [0:N];
  logic [N-1:0]  c_m   [0:N];
  logic [TW-1:0] c_tgt [0:N];
  logic [N-1:0]  c_q   [0:N];
  logic [SW-1:0] c_q2  [0:N];
  logic [TW-1:0] c_q3  [0:N];
  logic          c_rdy [0:N];
  logic          front_rdy;
  logic [W-1:0]  out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbc_pkg::CFG_IDX_CRUSH: cfg_r.crush_enable     <= cfg_data[0];
        mbc_pkg::CFG_IDX_MASK:  cfg_r.bit_mask         <= cfg_data[mbc_pkg::MASK_W-1:0];
        mbc_pkg::CFG_IDX_XOR:   cfg_r.xor_enable       <= cfg_data[0];
        mbc_pkg::CFG_IDX_AND:   cfg_r.and_enable       <= cfg_data[0];
        mbc_pkg::CFG_IDX_CUBE:  cfg_r.cube_root_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_sample ($unsigned(in_sample_in)),
    .up_rdy    (front_rdy),
    .dn_ctl    (c_ctl[0]),
    .dn_raw    (c_raw[0]),
    .dn_m      (c_m[0]),
    .dn_tgt    (c_tgt[0]),
    .dn_rdy    (c_rdy[0])
  );

  assign in_stall = !front_rdy;
  assign c_q[0]   = '0;
  assign c_q2[0]  = '0;
  assign c_q3[0]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    mbc_root_cell #(.SAMPLE_BITS(SAMPLE_BITS), .BIT(N - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_ctl (c_ctl[k]),
      .up_raw (c_raw[k]),
      .up_m   (c_m[k]),
      .up_tgt (c_tgt[k]),
      .up_q   (c_q[k]),
      .up_q2  (c_q2[k]),
      .up_q3  (c_q3[k]),
      .up_rdy (c_rdy[k]),
      .dn_ctl (c_ctl[k+1]),
      .dn_raw (c_raw[k+1]),
      .dn_m   (c_m[k+1]),
      .dn_tgt (c_tgt[k+1]),
      .dn_q   (c_q[k+1]),
      .dn_q2  (c_q2[k+1]),
      .dn_q3  (c_q3[k+1]),
      .dn_rdy (c_rdy[k+1])
    );
  end

  mbc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_ctl     (c_ctl[N]),
    .up_raw     (c_raw[N]),
    .up_m       (c_m[N]),
    .up_q       (c_q[N]),
    .up_rdy     (c_rdy[N]),
    .out_valid  (out_valid),
    .out_sample (out_word),
    .out_stall  (out_stall)
  );

  assign out_sample_out = $signed(out_word);

endmodule

`default_nettype wire
